>>> rtl/core/rcpd_pkg.sv
package rcpd_pkg;

    // field widths of the stream items
    localparam int LEVEL_W   = 8;
    localparam int TIME_W    = 16;
    localparam int CHAN_W    = 3;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * TIME_W;
    localparam int MAX_LANES = 8;

    // divider sequencing
    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_USED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_MIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_MAX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX       = 3'd4;

    // register values after reset
    localparam logic [3:0]              RST_CHANNELS_USED = 4'd8;
    localparam logic [TIME_W-1:0]       RST_IN_MIN        = 16'd1000;
    localparam logic [TIME_W-1:0]       RST_IN_MAX        = 16'd2000;
    localparam logic signed [VAL_W-1:0] RST_OUT_MIN       = 16'sd0;
    localparam logic signed [VAL_W-1:0] RST_OUT_MAX       = 16'sd256;

    localparam logic signed [VAL_W+1:0] VAL_POS_LIMIT = 18'sd32767;
    localparam logic signed [VAL_W-1:0] VAL_POS_MAX   = 16'sh7fff;

    // input request
    typedef struct packed {
        logic [LEVEL_W-1:0] levels;
        logic [TIME_W-1:0]  time_us;
    } t_in_item;

    // result request
    typedef struct packed {
        logic [CHAN_W-1:0]       channel;
        logic [TIME_W-1:0]       width_us;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_out_item;

    // sequencer to lanes
    typedef struct packed {
        logic accept;
        logic clamp;
        logic mul;
        logic div_step;
    } t_lane_ctl;

    // shared scaling setup seen by every lane
    typedef struct packed {
        logic [TIME_W-1:0] in_min;
        logic [TIME_W-1:0] in_max;
        logic [TIME_W-1:0] in_span;
        logic [TIME_W-1:0] out_span;
    } t_scale_cfg;

    // sequencer to merger
    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] out_min;
        logic                    span_zero;
    } t_merge_ctl;

    // merger to sequencer
    typedef struct packed {
        logic done;
    } t_merge_stat;

    // magnitude of the difference of two unsigned words
    function automatic logic [TIME_W-1:0] abs_diff_u(input logic [TIME_W-1:0] a,
                                                     input logic [TIME_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // magnitude of the difference of two signed words, always fits unsigned
    function automatic logic [TIME_W-1:0] abs_diff_s(input logic signed [VAL_W-1:0] a,
                                                     input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] d;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        return d[VAL_W] ? TIME_W'(-d) : d[TIME_W-1:0];
    endfunction

endpackage

>>> rtl/core/rcpd_in_if.sv
interface rcpd_in_if import rcpd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/rcpd_out_if.sv
interface rcpd_out_if import rcpd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/rcpd_lane.sv
module rcpd_lane import rcpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic              i_active,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_time_us,
    input  t_scale_cfg        i_cfg,
    output logic              o_fall,
    output logic [TIME_W-1:0] o_width_us,
    output logic [VAL_W-1:0]  o_quotient
);

    logic              r_prev;
    logic [TIME_W-1:0] r_rise;
    logic              r_fall;
    logic [TIME_W-1:0] r_width;
    logic [TIME_W-1:0] r_dist;
    logic [TIME_W-1:0] r_rem;
    logic [VAL_W-1:0]  r_quo;

    logic [TIME_W-1:0] w_clamped;
    logic [PROD_W-1:0] w_prod;
    logic [TIME_W:0]   w_trial;
    logic [TIME_W:0]   w_diff;
    logic              w_fit;

    // edge detect and rise timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 1'b0;
            r_rise <= '0;
            r_fall <= 1'b0;
        end else if (i_ctl.accept) begin
            r_fall <= i_active && r_prev && !i_level;
            if (i_active && (i_level != r_prev)) begin
                r_prev <= i_level;
                if (i_level) begin
                    r_rise <= i_time_us;
                end
            end
        end
    end

    // clamp to the input range, inverted limits fall out of the order of tests
    always_comb begin
        if (r_width < i_cfg.in_min) begin
            w_clamped = i_cfg.in_min;
        end else if (r_width > i_cfg.in_max) begin
            w_clamped = i_cfg.in_max;
        end else begin
            w_clamped = r_width;
        end
    end

    assign w_prod  = r_dist * i_cfg.out_span;
    assign w_trial = {r_rem, r_quo[VAL_W-1]};
    assign w_fit   = w_trial >= {1'b0, i_cfg.in_span};
    assign w_diff  = w_trial - {1'b0, i_cfg.in_span};

    // width, distance, product, then one restoring divide bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_width <= i_time_us - r_rise;
        end
        if (i_ctl.clamp) begin
            r_dist <= abs_diff_u(w_clamped, i_cfg.in_min);
        end
        if (i_ctl.mul) begin
            r_rem <= w_prod[PROD_W-1:VAL_W];
            r_quo <= w_prod[VAL_W-1:0];
        end else if (i_ctl.div_step) begin
            r_rem <= w_fit ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
            r_quo <= {r_quo[VAL_W-2:0], w_fit};
        end
    end

    assign o_fall     = r_fall;
    assign o_width_us = r_width;
    assign o_quotient = r_quo;

endmodule

>>> rtl/core/rcpd_merge.sv
module rcpd_merge import rcpd_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_merge_ctl                     i_ctl,
    input  logic [LANES-1:0]               i_fall,
    input  logic [LANES-1:0][TIME_W-1:0]   i_width,
    input  logic [LANES-1:0][VAL_W-1:0]    i_quotient,
    rcpd_out_if.source                     o_out,
    output t_merge_stat                    o_stat
);

    logic [LANES-1:0]  r_pend;
    logic              r_ov;
    t_out_item         r_item;

    logic [LANES-1:0]        w_rest;
    logic [LANES-1:0]        w_pick;
    logic [CHAN_W-1:0]       w_chan;
    logic [TIME_W-1:0]       w_width;
    logic [VAL_W-1:0]        w_quo;
    logic signed [VAL_W+1:0] w_sum;
    logic signed [VAL_W-1:0] w_value;
    logic                    w_load;

    // lowest pending lane as a one-hot pick
    assign w_rest = r_pend & (r_pend - 1'b1);
    assign w_pick = r_pend & ~w_rest;

    // and-or select of the picked lane
    always_comb begin
        w_chan  = '0;
        w_width = '0;
        w_quo   = '0;
        for (int i = 0; i < LANES; i++) begin
            if (w_pick[i]) begin
                w_chan  = w_chan | CHAN_W'(i);
                w_width = w_width | i_width[i];
                w_quo   = w_quo | i_quotient[i];
            end
        end
    end

    // offset by out_min and saturate at the top; a zero input span gives out_min
    assign w_sum = {{2{i_ctl.out_min[VAL_W-1]}}, i_ctl.out_min} + {2'b00, w_quo};

    always_comb begin
        if (i_ctl.span_zero) begin
            w_value = i_ctl.out_min;
        end else if (w_sum > VAL_POS_LIMIT) begin
            w_value = VAL_POS_MAX;
        end else begin
            w_value = w_sum[VAL_W-1:0];
        end
    end

    assign w_load = (r_pend != '0) && (!r_ov || o_out.ready);

    // pending mask and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_pend <= i_fall;
            end else if (w_load) begin
                r_pend <= w_rest;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.channel  <= w_chan;
            r_item.width_us <= w_width;
            r_item.value    <= w_value;
            r_item.last     <= (w_rest == '0);
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_item;
    assign o_stat.done = (r_pend == '0);

endmodule

>>> rtl/core/rc_pwm_pulse_decoder.sv
// sequence: an accepted sample runs through the clamp, multiply and divide states, then its
//   results follow in the emit state, one result per cycle while the result side is ready
// samples: a new sample is taken only in idle, once every result of the last one has been loaded
//   into the output register after the 16-step restoring divider that every channel lane runs in parallel
// reset: synchronous active low; clears pin history, rise times, pending results and
//   loads the default ranges (8 channels, 1000..2000 us to 0..1.0)
module rc_pwm_pulse_decoder import rcpd_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rcpd_in_if.sink              i_in,
    rcpd_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int LANES = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLAMP = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [3:0]              r_channels_used;
    logic [TIME_W-1:0]       r_in_min;
    logic [TIME_W-1:0]       r_in_max;
    logic signed [VAL_W-1:0] r_out_min;
    logic signed [VAL_W-1:0] r_out_max;
    logic [TIME_W-1:0]       r_in_span;
    logic [TIME_W-1:0]       r_out_span;

    logic                           w_accept;
    logic                           w_last_step;
    t_lane_ctl                      w_lane_ctl;
    t_scale_cfg                     w_scale;
    t_merge_ctl                     w_merge_ctl;
    t_merge_stat                    w_stat;
    logic [LANES-1:0]               w_fall;
    logic [LANES-1:0][TIME_W-1:0]   w_width;
    logic [LANES-1:0][VAL_W-1:0]    w_quo;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels_used <= RST_CHANNELS_USED;
            r_in_min        <= RST_IN_MIN;
            r_in_max        <= RST_IN_MAX;
            r_out_min       <= RST_OUT_MIN;
            r_out_max       <= RST_OUT_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNELS_USED: r_channels_used <= i_cfg_data[3:0];
                CFG_IN_MIN:        r_in_min        <= i_cfg_data[TIME_W-1:0];
                CFG_IN_MAX:        r_in_max        <= i_cfg_data[TIME_W-1:0];
                CFG_OUT_MIN:       r_out_min       <= i_cfg_data[VAL_W-1:0];
                CFG_OUT_MAX:       r_out_max       <= i_cfg_data[VAL_W-1:0];
                default:           ;
            endcase
        end
    end

    // range spans, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_in_span  <= abs_diff_u(r_in_max, r_in_min);
        r_out_span <= abs_diff_s(r_out_max, r_out_min);
    end

    // sequencer
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_last_step = (r_state == S_DIV) && (r_step == STEP_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (w_last_step) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_stat.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    assign w_lane_ctl.accept   = w_accept;
    assign w_lane_ctl.clamp    = (r_state == S_CLAMP);
    assign w_lane_ctl.mul      = (r_state == S_MUL);
    assign w_lane_ctl.div_step = (r_state == S_DIV);

    assign w_scale.in_min   = r_in_min;
    assign w_scale.in_max   = r_in_max;
    assign w_scale.in_span  = r_in_span;
    assign w_scale.out_span = r_out_span;

    assign w_merge_ctl.start     = w_last_step;
    assign w_merge_ctl.out_min   = r_out_min;
    assign w_merge_ctl.span_zero = (r_in_span == '0);

    // one lane per channel, up to MAX_LANES lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rcpd_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_lane_ctl),
            .i_active   (r_channels_used > 4'(g)),
            .i_level    (i_in.data.levels[g]),
            .i_time_us  (i_in.data.time_us),
            .i_cfg      (w_scale),
            .o_fall     (w_fall[g]),
            .o_width_us (w_width[g]),
            .o_quotient (w_quo[g])
        );
    end

    // results in ascending channel order
    rcpd_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_merge_ctl),
        .i_fall     (w_fall),
        .i_width    (w_width),
        .i_quotient (w_quo),
        .o_out      (o_out),
        .o_stat     (w_stat)
    );

    // nothing left to emit once the sequencer is back in idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> w_stat.done)
        else $error("idle with results still pending");

    // a sample holds off the next one while it is worked on
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second sample taken while the lanes are busy");

    // a result not flagged last must have more behind it
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.last) |-> !w_stat.done)
        else $error("result without last flag but nothing pending");

endmodule
